[hw/rtl/avs_pkg.sv]
// Shared types, constants and character mapping functions for the
// alphanumeric shift cipher. No dependencies.
package avs_pkg;

	localparam int unsigned KEY_ENTRIES_MAX = 8;
	localparam int unsigned SHIFT_W         = 6;
	localparam int unsigned KEY_W           = KEY_ENTRIES_MAX * SHIFT_W;
	localparam int unsigned LEN_W           = 4;
	localparam int unsigned POS_W           = 3;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned QUEUE_DEPTH     = 2;

	localparam logic [SHIFT_W-1:0] ALPHA_SIZE = 6'd62;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_SHIFTS   = 2'd0,
		REG_KEY_LENGTH   = 2'd1,
		REG_DECRYPT_MODE = 2'd2,
		REG_UNUSED       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       msg_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       passed_through;
		logic       out_last;
	} out_item_t;

	// one classified byte waiting in the queue
	typedef struct packed {
		logic [7:0]         raw_byte;
		logic [SHIFT_W-1:0] sym;
		logic [SHIFT_W-1:0] shift;
		logic               pass;
		logic               last;
		logic               decrypt;
	} queue_entry_t;

	// index 0..61, or 62 when not alphanumeric
	function automatic logic [SHIFT_W-1:0] symbol_index(input logic [7:0] b);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (b >= 8'd97 && b <= 8'd122) begin
				t = b - 8'd97;
			end else if (b >= 8'd65 && b <= 8'd90) begin
				t = b - 8'd65 + 8'd26;
			end else if (b >= 8'd48 && b <= 8'd57) begin
				t = b - 8'd48 + 8'd52;
			end else begin
				t = {2'b00, ALPHA_SIZE};
			end
			return t[SHIFT_W-1:0];
		end
	endfunction

	// index 0..61 back to its character
	function automatic logic [7:0] symbol_char(input logic [SHIFT_W-1:0] idx);
		logic [7:0] w;
		begin
			w = {2'b00, idx};
			if (idx < 6'd26) begin
				return w + 8'd97;
			end else if (idx < 6'd52) begin
				return w - 8'd26 + 8'd65;
			end else begin
				return w - 8'd52 + 8'd48;
			end
		end
	endfunction

endpackage

[hw/rtl/avs_front.sv]
// Front end: configuration registers, key position counter and byte
// classification. Depends on avs_pkg.
module avs_front #(
	parameter int unsigned KEY_ENTRIES = avs_pkg::KEY_ENTRIES_MAX
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [avs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [avs_pkg::KEY_W-1:0]      cfg_data,
	input  logic                           accept,
	input  avs_pkg::in_item_t              item,
	output avs_pkg::queue_entry_t          entry
);

	localparam int unsigned STORE_W = KEY_ENTRIES * avs_pkg::SHIFT_W;

	logic [STORE_W-1:0]              key_q;
	logic [avs_pkg::LEN_W-1:0]       key_len_q;
	logic                            decrypt_q;
	logic [avs_pkg::POS_W-1:0]       pos_q;

	logic [avs_pkg::LEN_W-1:0]       len_eff;
	logic [avs_pkg::POS_W-1:0]       pos;
	logic [avs_pkg::LEN_W-1:0]       next_pos;
	logic [avs_pkg::SHIFT_W-1:0]     raw_shift;
	logic [avs_pkg::SHIFT_W-1:0]     sym;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			key_len_q <= avs_pkg::LEN_W'(1);
			decrypt_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (avs_pkg::cfg_reg_t'(cfg_index))
				avs_pkg::REG_KEY_SHIFTS:   key_q     <= cfg_data[STORE_W-1:0];
				avs_pkg::REG_KEY_LENGTH:   key_len_q <= cfg_data[avs_pkg::LEN_W-1:0];
				avs_pkg::REG_DECRYPT_MODE: decrypt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (key_len_q == '0) begin
			len_eff = avs_pkg::LEN_W'(1);
		end else if (key_len_q > avs_pkg::LEN_W'(KEY_ENTRIES)) begin
			len_eff = avs_pkg::LEN_W'(KEY_ENTRIES);
		end else begin
			len_eff = key_len_q;
		end
		// length may have been lowered under the counter
		pos = ({1'b0, pos_q} >= len_eff) ? '0 : pos_q;
		raw_shift = '0;
		for (int i = 0; i < KEY_ENTRIES; i++) begin
			if (pos == avs_pkg::POS_W'(i)) begin
				raw_shift = key_q[i*avs_pkg::SHIFT_W +: avs_pkg::SHIFT_W];
			end
		end
		next_pos = {1'b0, pos} + avs_pkg::LEN_W'(1);
		sym = avs_pkg::symbol_index(item.in_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (item.msg_end || next_pos >= len_eff) begin
				pos_q <= '0;
			end else begin
				pos_q <= next_pos[avs_pkg::POS_W-1:0];
			end
		end
	end

	always_comb begin
		entry.raw_byte = item.in_byte;
		entry.sym      = sym;
		entry.shift    = (raw_shift >= avs_pkg::ALPHA_SIZE) ?
			raw_shift - avs_pkg::ALPHA_SIZE : raw_shift;
		entry.pass     = (sym == avs_pkg::ALPHA_SIZE);
		entry.last     = item.msg_end;
		entry.decrypt  = decrypt_q;
	end

endmodule

[hw/rtl/avs_queue.sv]
// Two-entry queue between front and back end.
// Depends on avs_pkg.
module avs_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  avs_pkg::queue_entry_t push_data,
	input  logic                  pop,
	output logic                  full,
	output logic                  not_empty,
	output avs_pkg::queue_entry_t head
);

	localparam int unsigned PTR_W = $clog2(avs_pkg::QUEUE_DEPTH);

	avs_pkg::queue_entry_t           mem_q [avs_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]                wr_ptr_q;
	logic [PTR_W-1:0]                rd_ptr_q;
	logic [PTR_W:0]                  count_q;

	assign full      = (count_q == (PTR_W+1)'(avs_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

[hw/rtl/avs_back.sv]
// Back end: modulo-62 shift, mapping back to a character and the
// output register. Depends on avs_pkg.
module avs_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_not_empty,
	input  avs_pkg::queue_entry_t q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output avs_pkg::out_item_t    out_data
);

	logic                       out_valid_q;
	avs_pkg::out_item_t         out_q;
	logic [avs_pkg::SHIFT_W:0]  addend;
	logic [avs_pkg::SHIFT_W:0]  sum;
	logic [avs_pkg::SHIFT_W-1:0] idx;
	avs_pkg::out_item_t         result;

	assign q_pop     = q_not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		// backward shift as forward by 62 - shift; sum stays below 124
		addend = q_head.decrypt ?
			{1'b0, avs_pkg::ALPHA_SIZE} - {1'b0, q_head.shift} : {1'b0, q_head.shift};
		sum = {1'b0, q_head.sym} + addend;
		if (sum >= {1'b0, avs_pkg::ALPHA_SIZE}) begin
			sum = sum - {1'b0, avs_pkg::ALPHA_SIZE};
		end
		idx = sum[avs_pkg::SHIFT_W-1:0];
		result.out_byte       = q_head.pass ? q_head.raw_byte : avs_pkg::symbol_char(idx);
		result.passed_through = q_head.pass;
		result.out_last       = q_head.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= result;
		end
	end

endmodule

[hw/rtl/alnum_vigenere_shift.sv]
// Top level of the alphanumeric Vigenere shift cipher.
// Depends on avs_pkg, avs_front, avs_queue and avs_back.
//
// Usage:
//  - Input channel (in_valid / in_stall / in_data) carries one message byte
//    and its end-of-message mark per transaction. Output channel
//    (out_valid / out_stall / out_data) returns one transaction per input
//    transaction, in order: the shifted character, a pass-through flag for
//    bytes outside a-z, A-Z, 0-9, and a copy of the end mark.
//  - Configuration: cfg_we with cfg_index 0 (key shifts, 6 bits per entry,
//    entry 0 lowest), 1 (key length), 2 (decrypt mode). Other indices are
//    ignored. Write only while the block is idle.
//  - Path: with nothing older waiting, an accepted byte is written into the queue
//    and then loaded into the output register, which raises out_valid.
//  - Throughput: one byte per cycle, sustained while out_stall is low. The back end does one
//    compare-and-subtract for the modulo-62 wrap.
//  - Reset: key shifts 0, key length 1, encrypt mode, key position 0,
//    queue and output register empty.
//  - Stall: while out_stall is high a valid result in the output register holds; the queue
//    absorbs up to two further bytes, after which in_stall is raised.
//  - Key position advances on every byte and returns to 0 after a byte
//    marked as message end.
module alnum_vigenere_shift #(
	parameter int unsigned KEY_ENTRIES = avs_pkg::KEY_ENTRIES_MAX
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [avs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [avs_pkg::KEY_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  avs_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output avs_pkg::out_item_t             out_data
);

	logic                  accept;
	logic                  q_full;
	logic                  q_not_empty;
	logic                  q_pop;
	avs_pkg::queue_entry_t entry;
	avs_pkg::queue_entry_t q_head;

	// stall depends only on queue occupancy, never on in_valid
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	avs_front #(
		.KEY_ENTRIES(KEY_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (in_data),
		.entry     (entry)
	);

	avs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (entry),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	avs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for alnum_vigenere_shift: directed and random message
// transactions, each result checked against an in-bench model of the cipher.
// Depends on avs_pkg and the alnum_vigenere_shift RTL.

module tb_top;
	import avs_pkg::*;

	localparam int CYCLE_LIMIT = 300000; // far above the slowest legal run
	localparam int MAX_GAP     = 11;     // longest sender gap / receiver stall per transaction
	localparam int SETTLE      = 4;      // queue and output register path plus margin
	localparam int SYMBOLS     = 62;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 42;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;

	// Shadow copy of the cipher state and registers
	logic [KEY_W-1:0] key_reg;
	logic [LEN_W-1:0] len_reg;
	logic             decrypt_reg;
	int               key_pos;

	// Character <-> alphabet rank lookup, built at time zero
	logic [7:0] glyph [SYMBOLS];
	int         rank_tbl [256];

	out_item_t expected_q [$];
	int        fail_count;
	int        in_gap_max;
	int        stall_max;
	int        cycle_count;

	alnum_vigenere_shift dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: ends a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// a-z ranks 0..25, A-Z 26..51, 0-9 52..61; anything else has no rank (-1)
	function automatic void init_tables();
		for (int c = 0; c < 256; c++) rank_tbl[c] = -1;
		for (int i = 0; i < 26; i++) begin
			glyph[i]      = 8'(97 + i);
			glyph[26 + i] = 8'(65 + i);
		end
		for (int i = 0; i < 10; i++) glyph[52 + i] = 8'(48 + i);
		for (int i = 0; i < SYMBOLS; i++) rank_tbl[glyph[i]] = i;
	endfunction

	// Expected result of one accepted byte; advances the shadow key position.
	function automatic out_item_t cipher_byte(input in_item_t it);
		out_item_t r;
		int        len;
		int        pos;
		int        shift;
		int        idx;
		len = int'(len_reg);
		if (len == 0) len = 1;                            // zero length acts as one entry
		if (len > KEY_ENTRIES_MAX) len = KEY_ENTRIES_MAX; // saturate over-long keys
		// position left beyond a shortened key restarts at entry 0
		pos   = (key_pos < len) ? key_pos : 0;
		shift = int'(key_reg[pos * SHIFT_W +: SHIFT_W]) % SYMBOLS; // entries 62, 63 wrap
		idx   = rank_tbl[it.in_byte];
		r.out_last = it.msg_end;
		if (idx < 0) begin
			// not alphanumeric: byte goes through untouched and flagged
			r.out_byte       = it.in_byte;
			r.passed_through = 1'b1;
		end else begin
			idx = decrypt_reg ? (idx + SYMBOLS - shift) % SYMBOLS : (idx + shift) % SYMBOLS;
			r.out_byte       = glyph[idx];
			r.passed_through = 1'b0;
		end
		// position steps on every byte, pass-through ones included
		key_pos = (it.msg_end || pos + 1 >= len) ? 0 : pos + 1;
		return r;
	endfunction

	// Register write at a falling edge; only called with the pipeline empty.
	task automatic write_reg(input cfg_reg_t idx, input logic [KEY_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		case (idx)
			REG_KEY_SHIFTS:   key_reg = value;
			REG_KEY_LENGTH:   len_reg = value[LEN_W-1:0];
			REG_DECRYPT_MODE: decrypt_reg = value[0];
			default: ; // unused index, the block ignores it
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Sender hold-off: drop valid and wait for every outstanding result.
	task automatic wait_for_results();
		in_valid = 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// One input transaction: random gap, then hold the payload until accepted.
	// Entered and left at a falling edge; valid stays high into a zero-gap successor.
	task automatic send_byte(input logic [7:0] b, input logic last);
		in_item_t it;
		int       gap;
		it.in_byte = b;
		it.msg_end = last;
		gap = $urandom_range(in_gap_max, 0);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  = it;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_q.push_back(cipher_byte(it));
		@(negedge clk);
	endtask

	task automatic send_text(input string s, input logic end_mark);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], end_mark && (i == s.len() - 1));
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (expected_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("unexpected result: byte %02h pass %0b last %0b",
					got.out_byte, got.passed_through, got.out_last);
			end
		end else begin
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte || got.passed_through !== want.passed_through
					|| got.out_last !== want.out_last) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("mismatch: expected byte %02h pass %0b last %0b, got byte %02h pass %0b last %0b",
						want.out_byte, want.passed_through, want.out_last,
						got.out_byte, got.passed_through, got.out_last);
				end
			end
		end
	endtask

	// Receiver: random stall before each transaction, then take the next result.
	initial begin : result_monitor
		int gap;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = $urandom_range(stall_max, 0);
			if (gap != 0) begin
				out_stall = 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall = 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_result(out_data);
		end
	end

	// Reset values: zero key, one entry, encrypt -> identity on alphanumerics.
	// Also covers the alphabet boundaries and the byte extremes.
	task automatic test_reset_state();
		send_byte("a", 1'b0);
		send_byte("Z", 1'b0);
		send_byte("0", 1'b0);
		send_byte("9", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte("@", 1'b0);
		send_byte("{", 1'b1);
	endtask

	// Full eight-entry key with entries 61, 62, 63 and 0; over-long length
	// saturates; a write to the unused index must change nothing.
	task automatic test_key_extremes();
		wait_for_results();
		write_reg(REG_KEY_SHIFTS, {6'd2, 6'd60, 6'd1, 6'd0, 6'd63, 6'd62, 6'd61, 6'd63});
		write_reg(REG_KEY_LENGTH, KEY_W'(15));
		write_reg(REG_UNUSED, '1);
		send_text("z9Za0/Mm", 1'b1);
	endtask

	// Decrypt with a zero key length (acts as one entry) and shift 61.
	task automatic test_decrypt_short_key();
		wait_for_results();
		write_reg(REG_DECRYPT_MODE, KEY_W'(1));
		write_reg(REG_KEY_LENGTH, KEY_W'(0));
		write_reg(REG_KEY_SHIFTS, 48'hFFFF_FFFF_FFFD);
		send_text("a0A9", 1'b1);
	endtask

	// Leave the position at entry 5 mid-message, then shorten the key to 3:
	// the next byte must use entry 0.
	task automatic test_lowered_length();
		wait_for_results();
		write_reg(REG_DECRYPT_MODE, KEY_W'(0));
		write_reg(REG_KEY_LENGTH, KEY_W'(8));
		write_reg(REG_KEY_SHIFTS, 48'h1234_5678_9ABC);
		send_text("abcde", 1'b0);
		wait_for_results();
		write_reg(REG_KEY_LENGTH, KEY_W'(3));
		send_text("xy", 1'b1);
	endtask

	// Random messages over several register settings and idling patterns.
	// Mostly alphanumeric text, with a quarter arbitrary bytes.
	task automatic test_random_messages();
		int         sent;
		int         msg_len;
		logic [7:0] b;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_for_results();
			case (ph)
				0: begin
					// all-ones key, saturated length, back-to-back transactions
					write_reg(REG_KEY_SHIFTS, '1);
					write_reg(REG_KEY_LENGTH, KEY_W'(15));
					write_reg(REG_DECRYPT_MODE, KEY_W'(0));
					in_gap_max = 0;
					stall_max  = 0;
				end
				1: begin
					write_reg(REG_KEY_SHIFTS, '0);
					write_reg(REG_KEY_LENGTH, KEY_W'(1));
					write_reg(REG_DECRYPT_MODE, KEY_W'(1));
					in_gap_max = MAX_GAP;
					stall_max  = MAX_GAP;
				end
				2: begin
					// sender flat out against a slow receiver: queue fills, in_stall rises
					write_reg(REG_KEY_SHIFTS, KEY_W'({$urandom, $urandom}));
					write_reg(REG_KEY_LENGTH, KEY_W'(8));
					write_reg(REG_DECRYPT_MODE, KEY_W'($urandom_range(1, 0)));
					in_gap_max = 0;
					stall_max  = MAX_GAP;
				end
				default: begin
					write_reg(REG_KEY_SHIFTS, KEY_W'({$urandom, $urandom}));
					write_reg(REG_KEY_LENGTH, KEY_W'($urandom_range(15, 0)));
					write_reg(REG_DECRYPT_MODE, KEY_W'($urandom_range(1, 0)));
					if ($urandom_range(1, 0) != 0) write_reg(REG_UNUSED, KEY_W'({$urandom, $urandom}));
					in_gap_max = ($urandom_range(1, 0) != 0) ? MAX_GAP : 0;
					stall_max  = ($urandom_range(1, 0) != 0) ? MAX_GAP : 0;
				end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				msg_len = $urandom_range(24, 1);
				for (int i = 0; i < msg_len; i++) begin
					b = ($urandom_range(3, 0) != 0) ? glyph[$urandom_range(SYMBOLS - 1, 0)]
						: 8'($urandom_range(255, 0));
					send_byte(b, i == msg_len - 1);
				end
				sent += msg_len;
				// now and then, and always in phase 3, hold off until the pipe is empty
				if (ph == 3 || $urandom_range(7, 0) == 0) wait_for_results();
			end
		end
	endtask

	initial begin
		init_tables();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_KEY_SHIFTS;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		key_reg     = '0;
		len_reg     = LEN_W'(1);
		decrypt_reg = 1'b0;
		key_pos     = 0;
		fail_count  = 0;
		in_gap_max  = MAX_GAP;
		stall_max   = MAX_GAP;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_state();
		test_key_extremes();
		test_decrypt_short_key();
		test_lowered_length();
		test_random_messages();

		// drain the last transactions, then allow the pipeline latency
		wait_for_results();
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/avs_pkg.sv
hw/rtl/avs_front.sv
hw/rtl/avs_queue.sv
hw/rtl/avs_back.sv
hw/rtl/alnum_vigenere_shift.sv
verif/tb_top.sv
